### src/u8d_pkg.sv
package u8d_pkg;

    // Byte classes of the UTF-8 lead byte.
    localparam logic [7:0] LEAD_BAD_MIN = 8'b1111_1000;
    localparam logic [7:0] LEAD_4B_MIN  = 8'b1111_0000;
    localparam logic [7:0] LEAD_3B_MIN  = 8'b1110_0000;
    localparam logic [7:0] LEAD_2B_MIN  = 8'b1100_0000;
    localparam logic [7:0] BYTE_MASK    = 8'hff;

    localparam int POINT_W = 21;

    // Result codes carried on the status port.
    typedef enum logic [2:0] {
        ST_PENDING    = 3'd0,
        ST_READY      = 3'd1,
        ST_BAD_LEAD   = 3'd2,
        ST_SKIPPED    = 3'd3,
        ST_CONT_ERROR = 3'd4,
        ST_BLOCKED    = 3'd5
    } status_t;

    // One input request.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       buffer_end;
    } item_t;

    // One result.
    typedef struct packed {
        logic [POINT_W-1:0] code_point;
        status_t            status;
        logic               error_flag;
    } result_t;

endpackage

### src/u8d_decode.sv
module u8d_decode
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  u8d_pkg::item_t   item,
    output u8d_pkg::result_t result
);
    import u8d_pkg::*;

    logic [POINT_W-1:0] partial_reg;
    logic [POINT_W-1:0] partial_next;
    logic [1:0]         remaining_reg;
    logic [1:0]         remaining_next;
    logic               error_reg;
    logic               error_next;
    logic               skip_reg;
    logic               skip_next;

    logic [7:0]         b;
    logic [POINT_W-1:0] shifted;

    assign b       = item.byte_value & BYTE_MASK;
    assign shifted = {partial_reg[POINT_W-7:0], b[5:0]};

    // Decode one byte against the current sequence state.
    always_comb
    begin
        partial_next      = partial_reg;
        remaining_next    = remaining_reg;
        error_next        = error_reg;
        skip_next         = skip_reg;
        result.code_point = '0;
        result.status     = ST_PENDING;

        if (error_reg)
        begin
            result.status = ST_BLOCKED;
        end
        else if (skip_reg)
        begin
            result.status = ST_SKIPPED;
            if (item.buffer_end)
            begin
                skip_next = 1'b0;
            end
        end
        else if (remaining_reg == 2'd0)
        begin
            priority if (!b[7] || b < LEAD_2B_MIN)
            begin
                // ASCII byte or a lone continuation byte.
                result.code_point = {{(POINT_W-8){1'b0}}, b};
                result.status     = ST_READY;
                partial_next      = '0;
            end
            else if (b >= LEAD_BAD_MIN)
            begin
                result.status = ST_BAD_LEAD;
                if (!item.buffer_end)
                begin
                    skip_next = 1'b1;
                end
            end
            else if (b >= LEAD_4B_MIN)
            begin
                partial_next   = {{(POINT_W-3){1'b0}}, b[2:0]};
                remaining_next = 2'd3;
            end
            else if (b >= LEAD_3B_MIN)
            begin
                partial_next   = {{(POINT_W-4){1'b0}}, b[3:0]};
                remaining_next = 2'd2;
            end
            else
            begin
                partial_next   = {{(POINT_W-5){1'b0}}, b[4:0]};
                remaining_next = 2'd1;
            end
        end
        else
        begin
            if (b >= LEAD_2B_MIN)
            begin
                error_next    = 1'b1;
                result.status = ST_CONT_ERROR;
            end
            else
            begin
                partial_next   = shifted;
                remaining_next = remaining_reg - 2'd1;
                if (remaining_reg == 2'd1)
                begin
                    result.code_point = shifted;
                    result.status     = ST_READY;
                end
            end
        end

        result.error_flag = error_next;
    end

    // Sequence state advances once per byte handed to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            remaining_reg <= '0;
            error_reg     <= 1'b0;
            skip_reg      <= 1'b0;
        end
        else if (step)
        begin
            partial_reg   <= partial_next;
            remaining_reg <= remaining_next;
            error_reg     <= error_next;
            skip_reg      <= skip_next;
        end
    end

    // The error state never clears without a reset.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |=> error_reg)
        else $error("sticky error cleared");

    // A bad lead byte never raises the error.
    a_bad_lead_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.status == ST_BAD_LEAD |=> !error_reg)
        else $error("bad lead set the error");

    // Skipping bytes leaves an open sequence untouched.
    a_skip_keeps_seq: assert property (@(posedge clk) disable iff (!rst_n)
        step && skip_reg && !error_reg |=> $stable(remaining_reg) && $stable(partial_reg))
        else $error("skipped byte changed the open sequence");

endmodule

### src/utf8_stream_decoder.sv
// UTF-8 stream decoder.
// Input channel: in_valid / in_ready with byte_value and buffer_end; one
// byte per request, buffer_end marks the last byte of a software buffer.
// Output channel: out_valid / out_ready with code_point, status and
// error_flag; exactly one result for every accepted byte, in order.
// A byte goes through an input register, is decoded by short logic against
// the sequence state, and lands in the result register, which raises
// out_valid. One byte is accepted every cycle while results are taken,
// set by the single decode step per byte.
// When the receiver stalls, the result register holds its result, the input
// register holds one more byte, and then in_ready drops until out_ready
// returns; nothing is lost or repeated.
// Reset clears both valid bits, the open sequence, the skip state and the
// sticky error. Once the error is set, every byte gets the blocked status
// until the next reset.
module utf8_stream_decoder
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   byte_value,
    input  logic                         buffer_end,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [u8d_pkg::POINT_W-1:0]  code_point,
    output logic [2:0]                   status,
    output logic                         error_flag
);
    import u8d_pkg::*;

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    advance;

    // The input byte moves on whenever the result slot is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.byte_value <= byte_value;
            item_reg.buffer_end <= buffer_end;
        end
    end

    u8d_decode u_decode
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (result_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = result_reg.code_point;
    assign status     = result_reg.status;
    assign error_flag = result_reg.error_flag;

    // Only a finished code point carries a nonzero value.
    a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_reg.status != ST_READY |-> code_point == '0)
        else $error("code point set without ready status");

    // Error statuses always come with the error flag.
    a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_reg.status == ST_BLOCKED
                      || result_reg.status == ST_CONT_ERROR) |-> error_flag)
        else $error("error status without error flag");

    // A held input byte is not dropped while the output stalls.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg))
        else $error("held input byte lost");

endmodule
